// ----- sv/aws_pkg.sv -----
// ============================================================================
// aws_pkg: shared types and constants for the audio waveshaper
// Mode codes, register indexes, internal fixed-point widths and the word
// that travels down the shaper pipeline.
// ============================================================================
package aws_pkg;

    // Shaper mode codes
    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_CLEAN = 2'd1,
        MODE_HARD  = 2'd2,
        MODE_FOLD  = 2'd3
    } mode_t;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPER_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 1'b1;

    // Q4.12 gain
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    // Fixed-point layout: input scaled to 24 fraction bits, product has 36
    localparam int IN_FRAC  = 24;
    localparam int FRAC_W   = 36;
    localparam int VAL_W    = 42;   // |p| <= 2^40, folds stay within +-2^40
    localparam int SUM_W    = 44;   // 5*p
    localparam int S24_W    = 27;   // |s24| <= 3*2^24
    localparam int T_W      = 28;   // t <= 9*2^24
    localparam int NUM_W    = 30;   // 27*2^24 + t
    localparam int DEN_W    = 31;   // 27*2^24 + 9*t
    localparam int REM_W    = 31;   // partial remainder, always below den
    localparam int DIV_STEPS = 25;  // quotient <= 2^24
    localparam int QUO_W    = DIV_STEPS;
    localparam int PROD_W   = S24_W + QUO_W + 1;
    localparam int R_W      = 27;   // |r| <= 3*2^24

    localparam logic signed [VAL_W-1:0] ONE_V   = VAL_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [VAL_W-1:0] TWO_V   = VAL_W'(64'sd2 <<< FRAC_W);
    localparam logic signed [SUM_W-1:0] THREE_S = SUM_W'(64'sd3 <<< FRAC_W);
    localparam logic [NUM_W-1:0] NUM_BASE = NUM_W'(64'd27 << IN_FRAC);
    localparam logic [DEN_W-1:0] DEN_BASE = DEN_W'(64'd27 << IN_FRAC);

    // Word carried from stage to stage
    typedef struct packed {
        mode_t                     mode;
        logic                      neg;   // input sample sign
        logic                      sat;   // clean mode beyond +-3
        logic signed [VAL_W-1:0]   val;   // value with 36 fraction bits
        logic signed [S24_W-1:0]   s24;   // clean-mode argument, Q.24
        logic [DEN_W-1:0]          den;
        logic [REM_W-1:0]          rem;
        logic                      nbit;  // next numerator bit to shift in
        logic [QUO_W-1:0]          quo;
    } word_t;

    // Per-cell job select
    typedef struct packed {
        logic do_div;
        logic do_fold;
        logic fold_odd;
    } cell_ctl_t;

endpackage

// ----- sv/aws_front.sv -----
// ============================================================================
// aws_front: gain multiply and clean-mode preparation
// Four elastic stages: gain product, scale and clamp, square, and the
// numerator and denominator of the rational tanh term.
// ============================================================================
module aws_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      in_sample,
    input  aws_pkg::mode_t                     mode,
    input  logic [aws_pkg::GAIN_W-1:0]         gain,
    output logic                               out_valid,
    input  logic                               out_ready,
    output aws_pkg::word_t                     out_word
);

    localparam int NST     = 4;
    localparam int P_SHIFT = aws_pkg::IN_FRAC + 1 - SAMPLE_BITS;
    localparam int PRD_W   = SAMPLE_BITS + aws_pkg::GAIN_W + 1;
    localparam int SQ_W    = 2 * aws_pkg::S24_W;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vin;

    // stage payload
    logic signed [aws_pkg::VAL_W-1:0] p1_reg, p1_next;
    aws_pkg::mode_t                   mode1_reg, mode1_next;
    logic                             neg1_reg, neg1_next;
    aws_pkg::word_t                   w2_reg, w2_next;
    aws_pkg::word_t                   w3_reg, w3_next;
    logic [aws_pkg::T_W-1:0]          t3_reg, t3_next;
    aws_pkg::word_t                   w4_reg, w4_next;

    // combinational helpers
    logic [aws_pkg::GAIN_W-1:0]         gain_eff;
    logic signed [PRD_W-1:0]            prod;
    logic signed [aws_pkg::SUM_W-1:0]   s_val;
    logic signed [aws_pkg::SUM_W-1:0]   s_bias;
    logic signed [aws_pkg::SUM_W-1:0]   s_sh;
    logic                               sat_hi;
    logic                               sat_lo;
    logic signed [aws_pkg::VAL_W-1:0]   p_clamp;
    logic signed [SQ_W-1:0]             sq;
    logic [aws_pkg::NUM_W-1:0]          a_val;
    logic [aws_pkg::DEN_W-1:0]          d_val;

    // handshake: a stage takes a new word when empty or when it drains
    assign vin = {vld_reg[NST-2:0], in_valid};
    always_comb begin
        rdy[NST] = out_ready;
        for (int i = 0; i < NST; i++) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_word  = w4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    // stage 1: p = x * 2^(25-S) * gain; raw mode rides the hard path at unity
    always_comb begin
        gain_eff   = (mode == aws_pkg::MODE_RAW) ? aws_pkg::GAIN_UNITY : gain;
        prod       = in_sample * $signed({1'b0, gain_eff});
        p1_next    = aws_pkg::VAL_W'(prod) <<< P_SHIFT;
        mode1_next = mode;
        neg1_next  = in_sample[SAMPLE_BITS-1];
    end

    // stage 2: 5*p, soft clip thresholds, Q.24 cut, hard clamp
    always_comb begin
        s_val  = (aws_pkg::SUM_W'(p1_reg) <<< 2) + aws_pkg::SUM_W'(p1_reg);
        sat_hi = s_val > aws_pkg::THREE_S;
        sat_lo = s_val < -aws_pkg::THREE_S;
        s_bias = s_val + (s_val[aws_pkg::SUM_W-1] ? aws_pkg::SUM_W'(4095)
                                                  : aws_pkg::SUM_W'(0));
        s_sh   = s_bias >>> (aws_pkg::FRAC_W - aws_pkg::IN_FRAC);

        if (p1_reg > aws_pkg::ONE_V) begin
            p_clamp = aws_pkg::ONE_V;
        end else if (p1_reg < -aws_pkg::ONE_V) begin
            p_clamp = -aws_pkg::ONE_V;
        end else begin
            p_clamp = p1_reg;
        end

        w2_next      = '0;
        w2_next.mode = mode1_reg;
        w2_next.neg  = neg1_reg;
        w2_next.sat  = sat_hi | sat_lo;
        w2_next.s24  = s_sh[aws_pkg::S24_W-1:0];
        case (mode1_reg) inside
            aws_pkg::MODE_RAW, aws_pkg::MODE_HARD: begin
                w2_next.val = p_clamp;
            end
            aws_pkg::MODE_CLEAN: begin
                w2_next.val = sat_hi ? aws_pkg::ONE_V :
                              (sat_lo ? -aws_pkg::ONE_V : p1_reg);
            end
            default: begin
                w2_next.val = p1_reg;
            end
        endcase
    end

    // stage 3: t = s24^2 >> 24
    always_comb begin
        sq      = w2_reg.s24 * w2_reg.s24;
        t3_next = sq[aws_pkg::IN_FRAC +: aws_pkg::T_W];
        w3_next = w2_reg;
    end

    // stage 4: numerator 27+t and denominator 27+9t; divider state seeded
    always_comb begin
        a_val        = aws_pkg::NUM_BASE + aws_pkg::NUM_W'(t3_reg);
        d_val        = aws_pkg::DEN_BASE + (aws_pkg::DEN_W'(t3_reg) << 3)
                       + aws_pkg::DEN_W'(t3_reg);
        w4_next      = w3_reg;
        w4_next.rem  = aws_pkg::REM_W'(a_val >> 1);
        w4_next.nbit = a_val[0];
        w4_next.den  = d_val;
        w4_next.quo  = '0;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            p1_reg    <= p1_next;
            mode1_reg <= mode1_next;
            neg1_reg  <= neg1_next;
        end
        if (rdy[1]) begin
            w2_reg <= w2_next;
        end
        if (rdy[2]) begin
            w3_reg <= w3_next;
            t3_reg <= t3_next;
        end
        if (rdy[3]) begin
            w4_reg <= w4_next;
        end
    end

endmodule

// ----- sv/aws_cell.sv -----
// ============================================================================
// aws_cell: one cell of the shaper chain
// Resolves one quotient bit of the tanh divider when its divide job is set and,
// in fold mode, applies one fold step when its fold job is set, then hands the word to the next cell.
// ============================================================================
module aws_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  aws_pkg::cell_ctl_t    ctl,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aws_pkg::word_t        in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output aws_pkg::word_t        out_word
);

    logic                         valid_reg;
    aws_pkg::word_t               word_reg, word_next;
    logic [aws_pkg::REM_W:0]      rem_sh;
    logic [aws_pkg::REM_W:0]      diff;
    logic                         ge;

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // restoring divide step and fold step
    always_comb begin
        word_next = in_word;
        rem_sh    = {in_word.rem, in_word.nbit};
        diff      = rem_sh - {1'b0, in_word.den};
        ge        = rem_sh >= {1'b0, in_word.den};
        if (ctl.do_div) begin
            word_next.rem  = ge ? diff[aws_pkg::REM_W-1:0] : rem_sh[aws_pkg::REM_W-1:0];
            word_next.quo  = {in_word.quo[aws_pkg::QUO_W-2:0], ge};
            word_next.nbit = 1'b0;
        end
        if (ctl.do_fold && (in_word.mode == aws_pkg::MODE_FOLD)) begin
            if (ctl.fold_odd) begin
                // reflect about +1
                if (in_word.val > aws_pkg::ONE_V) begin
                    word_next.val = aws_pkg::TWO_V - in_word.val;
                end
            end else if (in_word.val[aws_pkg::VAL_W-1]) begin
                word_next.val = -in_word.val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- sv/aws_back.sv -----
// ============================================================================
// aws_back: result assembly and output register
// Multiplies s24 by the quotient, finishes the fold, picks the mode result
// and converts it to a saturated output sample.
// ============================================================================
module aws_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  aws_pkg::word_t                 in_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_BITS-1:0]  out_sample
);

    localparam int NST       = 3;
    localparam int OUT_SHIFT = aws_pkg::FRAC_W + 1 - SAMPLE_BITS;
    localparam logic signed [aws_pkg::VAL_W-1:0] OUT_RND =
        aws_pkg::VAL_W'((64'sd1 <<< OUT_SHIFT) - 64'sd1);
    localparam logic signed [aws_pkg::VAL_W-1:0] OUT_MAX =
        aws_pkg::VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [aws_pkg::VAL_W-1:0] OUT_MIN = -OUT_MAX - 1;
    localparam logic signed [aws_pkg::PROD_W-1:0] Q24_RND =
        aws_pkg::PROD_W'((64'sd1 <<< aws_pkg::IN_FRAC) - 64'sd1);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vin;

    aws_pkg::word_t                      w1_reg, w1_next;
    logic signed [aws_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [aws_pkg::VAL_W-1:0]    v2_reg, v2_next;
    logic signed [SAMPLE_BITS-1:0]       sample_reg, sample_next;

    logic signed [aws_pkg::PROD_W-1:0]   prod_rnd;
    logic signed [aws_pkg::PROD_W-1:0]   prod_sh;
    logic signed [aws_pkg::R_W-1:0]      r_q;
    logic signed [aws_pkg::VAL_W-1:0]    r36;
    logic signed [aws_pkg::VAL_W-1:0]    f_clip;
    logic signed [aws_pkg::VAL_W-1:0]    f_out;
    logic signed [aws_pkg::VAL_W-1:0]    v_rnd;
    logic signed [aws_pkg::VAL_W-1:0]    v_q;

    // elastic stage control
    assign vin = {vld_reg[NST-2:0], in_valid};
    always_comb begin
        rdy[NST] = out_ready;
        for (int i = 0; i < NST; i++) begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end
    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[NST-1];
    assign out_sample = sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    // stage 1: s24 * q
    always_comb begin
        w1_next   = in_word;
        prod_next = in_word.s24 * $signed({1'b0, in_word.quo});
    end

    // stage 2: r = s24*q / 2^24 toward zero; fold clamp and sign; mode select
    always_comb begin
        prod_rnd = prod_reg + (prod_reg[aws_pkg::PROD_W-1] ? Q24_RND
                                                          : aws_pkg::PROD_W'(0));
        prod_sh  = prod_rnd >>> aws_pkg::IN_FRAC;
        r_q      = prod_sh[aws_pkg::R_W-1:0];
        r36      = aws_pkg::VAL_W'(r_q) <<< (aws_pkg::FRAC_W - aws_pkg::IN_FRAC);
        f_clip   = (w1_reg.val > aws_pkg::ONE_V) ? aws_pkg::ONE_V : w1_reg.val;
        f_out    = w1_reg.neg ? -f_clip : f_clip;
        case (w1_reg.mode) inside
            aws_pkg::MODE_RAW, aws_pkg::MODE_HARD: begin
                v2_next = w1_reg.val;
            end
            aws_pkg::MODE_CLEAN: begin
                v2_next = w1_reg.sat ? w1_reg.val : r36;
            end
            aws_pkg::MODE_FOLD: begin
                v2_next = f_out;
            end
            default: begin
                v2_next = w1_reg.val;
            end
        endcase
    end

    // stage 3: drop to output precision toward zero and saturate
    always_comb begin
        v_rnd = v2_reg + (v2_reg[aws_pkg::VAL_W-1] ? OUT_RND : aws_pkg::VAL_W'(0));
        v_q   = v_rnd >>> OUT_SHIFT;
        if (v_q > OUT_MAX) begin
            sample_next = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (v_q < OUT_MIN) begin
            sample_next = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
            sample_next = v_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            w1_reg   <= w1_next;
            prod_reg <= prod_next;
        end
        if (rdy[1]) begin
            v2_reg <= v2_next;
        end
        if (rdy[2]) begin
            sample_reg <= sample_next;
        end
    end

endmodule

// ----- sv/audio_waveshaper.sv -----
// ============================================================================
// audio_waveshaper: memoryless sample waveshaper
// Raw, clean soft clip, hard clip and wavefolder shaping of a signed sample
// under a mode register and a Q4.12 drive gain.
// ============================================================================
// Usage:
//   Input words arrive on s_valid/s_ready/s_sample_in, shaped words leave on
//   m_valid/m_ready/m_sample_out; both sides transfer when valid and ready
//   are high at a clock edge. Registers are written through cfg_we,
//   cfg_index and cfg_data (index 0 shaper_mode, index 1 drive_gain) while
//   no words are in flight.
//   Throughput: one word per cycle, sustained while the receiver keeps m_ready high.
//   Depth: 7 + max(25, FOLD_STEPS) register stages, 32 at the default
//   parameters. The figure is set by the chain of cells: the tanh divider
//   resolves one quotient bit per cell (25 bits), and the wavefolder
//   applies one fold per cell; four front stages and three back stages
//   (including the output register) add the rest.
//   Reset (aresetn low at a clock edge) empties the pipeline and sets the
//   mode to raw and the gain to 1.0.
//   When the receiver stalls, each stage holds its word; empty stages keep
//   filling, so s_ready drops only once the whole chain is full.
// ============================================================================
module audio_waveshaper #(
    parameter int SAMPLE_BITS = 16,
    parameter int FOLD_STEPS  = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [aws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aws_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out
);

    localparam int NCELLS = (FOLD_STEPS > aws_pkg::DIV_STEPS) ? FOLD_STEPS
                                                               : aws_pkg::DIV_STEPS;

    aws_pkg::mode_t                  mode_reg;
    logic [aws_pkg::GAIN_W-1:0]      gain_reg;

    aws_pkg::word_t                  cw [NCELLS+1];
    logic [NCELLS:0]                 cv;
    logic [NCELLS:0]                 cr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= aws_pkg::MODE_RAW;
            gain_reg <= aws_pkg::GAIN_UNITY;
        end else if (cfg_we) begin
            unique case (cfg_index)
                aws_pkg::REG_SHAPER_MODE: mode_reg <= aws_pkg::mode_t'(cfg_data[1:0]);
                aws_pkg::REG_DRIVE_GAIN:  gain_reg <= cfg_data[aws_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // front stages
    aws_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_sample_in),
        .mode      (mode_reg),
        .gain      (gain_reg),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_word  (cw[0])
    );

    // chain of divide/fold cells
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        localparam aws_pkg::cell_ctl_t CTL = '{
            do_div:   (k < aws_pkg::DIV_STEPS),
            do_fold:  (k < FOLD_STEPS),
            fold_odd: ((k % 2) == 1)
        };
        aws_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (CTL),
            .in_valid  (cv[k]),
            .in_ready  (cr[k]),
            .in_word   (cw[k]),
            .out_valid (cv[k+1]),
            .out_ready (cr[k+1]),
            .out_word  (cw[k+1])
        );
    end

    // result assembly and output register
    aws_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cv[NCELLS]),
        .in_ready   (cr[NCELLS]),
        .in_word    (cw[NCELLS]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sample (m_sample_out)
    );

endmodule

// ----- sv/aws_checker.sv -----
// ============================================================================
// aws_checker: port-level assertions for the audio waveshaper
// Tracks words in flight and checks reset, output hold, occupancy and
// readiness of an empty pipeline.
// ============================================================================
module aws_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int FOLD_STEPS  = 10
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [SAMPLE_BITS-1:0]      m_sample_out
);

    localparam int NCELLS = (FOLD_STEPS > aws_pkg::DIV_STEPS) ? FOLD_STEPS
                                                               : aws_pkg::DIV_STEPS;
    localparam int DEPTH  = NCELLS + 7;
    localparam int CNT_W  = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] inflight_reg, inflight_next;

    // words accepted but not yet delivered
    always_comb begin
        inflight_next = inflight_reg
                        + CNT_W'(s_valid & s_ready)
                        - CNT_W'(m_valid & m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("stalled output word changed or dropped");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("output word without a matching input word");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more words in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == '0 |-> s_ready)
        else $error("empty pipeline refuses input");

endmodule

bind audio_waveshaper aws_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FOLD_STEPS  (FOLD_STEPS)
) u_aws_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the audio waveshaper
// Streams signed samples through raw, clean soft clip, hard clip and
// wavefolder settings at many drive gains. Each word that is sent is shaped
// by an in-bench fixed-point predictor, and each word that comes back is
// checked against the oldest prediction. Both handshake sides idle at random.
// ============================================================================
module tb_top;

    localparam int     FOLD_STEPS     = 10;
    localparam int     SETTLE_CYCLES  = 40;     // settle time after the queues drain
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RAND_PHASES    = 26;
    localparam int     HOLD_PHASE     = 8;
    localparam longint UNIT24         = 64'sd1 << 24;
    localparam longint UNIT36         = 64'sd1 << 36;
    localparam longint OUT_DIV        = 64'sd1 << 21;   // 36 -> 15 fraction bits

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_we      = 1'b0;
    logic [aws_pkg::CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [aws_pkg::CFG_DATA_W-1:0]    cfg_data    = '0;
    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    logic signed [15:0]                s_sample_in = '0;
    logic                              m_valid;
    logic                              m_ready     = 1'b0;
    logic signed [15:0]                m_sample_out;

    // Bench copy of the shaper registers
    aws_pkg::mode_t                    cur_mode    = aws_pkg::MODE_RAW;
    logic [aws_pkg::GAIN_W-1:0]        cur_gain    = aws_pkg::GAIN_UNITY;

    logic signed [15:0]      sample_q[$];   // samples waiting to be sent
    logic signed [15:0]      shaped_q[$];   // predicted output words
    int                      err_count   = 0;
    int                      idle_cycles = 0;
    int                      src_gap     = 0;
    int                      sink_gap    = 0;
    int                      hold_cnt    = 0;
    bit                      hold_done   = 1'b0;
    bit                      hold_req    = 1'b0;
    bit                      idle_en     = 1'b1;

    audio_waveshaper dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shaped output for one sample under the current mode and gain
    function automatic logic signed [15:0] shape_sample(input logic signed [15:0] smp);
        longint x, p, s, s24, t, q, r, v;
        x = smp;
        if (cur_mode == aws_pkg::MODE_RAW) return smp;
        p = x * 512 * longint'(cur_gain);     // 36 fraction bits
        case (cur_mode)
            aws_pkg::MODE_CLEAN: begin
                s = p * 5;
                if (s > 3 * UNIT36) begin
                    v = UNIT36;
                end else if (s < -3 * UNIT36) begin
                    v = -UNIT36;
                end else begin
                    s24 = s / 4096;
                    t = (s24 * s24) >> 24;
                    q = ((27 * UNIT24 + t) * UNIT24) / (27 * UNIT24 + 9 * t);
                    r = (s24 * q) / UNIT24;
                    v = r * 4096;
                end
            end
            aws_pkg::MODE_HARD: begin
                v = p;
                if (v > UNIT36) v = UNIT36;
                if (v < -UNIT36) v = -UNIT36;
            end
            default: begin
                // fold about one: even steps rectify, odd steps reflect
                v = p;
                for (int i = 0; i < FOLD_STEPS; i++) begin
                    if (i % 2 == 0) begin
                        if (v < 0) v = -v;
                    end else if (v > UNIT36) begin
                        v = 2 * UNIT36 - v;
                    end
                end
                if (v > UNIT36) v = UNIT36;
                if (smp < 0) v = -v;
            end
        endcase
        v = v / OUT_DIV;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Wait until no word is pending or in flight, then let the pipeline settle
    task automatic drain();
        while (sample_q.size() != 0 || s_valid || shaped_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both registers; upper mode bits carry noise the block must ignore
    task automatic set_shaper(input aws_pkg::mode_t m,
                              input logic [aws_pkg::GAIN_W-1:0] g);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= aws_pkg::REG_SHAPER_MODE;
        cfg_data  <= {14'($urandom), m};
        @(posedge aclk);
        cur_mode = m;
        cfg_index <= aws_pkg::REG_DRIVE_GAIN;
        cfg_data  <= g;
        @(posedge aclk);
        cur_gain = g;
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Sender: offers queued samples, predicts each word as it is taken
    always @(posedge aclk) begin : driver
        logic               nxt_valid;
        logic signed [15:0] nxt_smp;
        nxt_valid = s_valid;
        nxt_smp   = s_sample_in;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                shaped_q = {shaped_q, shape_sample(s_sample_in)};
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (idle_en && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 17) - 1;
                end else if (sample_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_smp   = sample_q.pop_front();
                end
            end
        end
        s_valid     <= nxt_valid;
        s_sample_in <= nxt_smp;
    end

    // Receiver: checks each word, stalls in bursts and once for a long stretch
    always @(posedge aclk) begin : monitor
        logic               nxt_ready;
        logic signed [15:0] want;
        nxt_ready = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (shaped_q.size() == 0) begin
                    $error("sample_out: no word expected, got %0d", m_sample_out);
                    err_count++;
                end else begin
                    want = shaped_q.pop_front();
                    if (m_sample_out !== want) begin
                        $error("sample_out: expected %0d, got %0d", want, m_sample_out);
                        err_count++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_cnt  = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 17) - 1;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_ready <= nxt_ready;
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        aws_pkg::mode_t              dir_mode [5];
        logic [aws_pkg::GAIN_W-1:0]  dir_gain [5];
        logic signed [15:0]          corner_smp [5];
        logic [aws_pkg::GAIN_W-1:0]  g;
        logic signed [15:0]          smp;
        int                          n_items;
        dir_mode   = '{aws_pkg::MODE_RAW, aws_pkg::MODE_CLEAN, aws_pkg::MODE_HARD,
                       aws_pkg::MODE_FOLD, aws_pkg::MODE_CLEAN};
        dir_gain   = '{aws_pkg::GAIN_UNITY, aws_pkg::GAIN_UNITY, 16'd8192, 16'hFFFF,
                       16'd0};
        corner_smp = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: first setting is the reset state; hard clip at gain 2
        // reaches plus one, full-gain folds land below minus one
        for (int d = 0; d < 5; d++) begin
            if (d > 0) begin
                drain();
                set_shaper(dir_mode[d], dir_gain[d]);
            end
            foreach (corner_smp[k]) sample_q = {sample_q, corner_smp[k]};
        end

        // Random phases, each with its own mode and gain
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            idle_en = (ph < RAND_PHASES - 4) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: g = 16'($urandom);
                1: g = 16'($urandom_range(0, 8192));
                2: g = 16'($urandom_range(0, 1024));
                default: begin
                    case ($urandom_range(0, 3))
                        0:       g = 16'd0;
                        1:       g = 16'hFFFF;
                        2:       g = aws_pkg::GAIN_UNITY;
                        default: g = 16'd1;
                    endcase
                end
            endcase
            set_shaper(aws_pkg::mode_t'($urandom_range(0, 3)), g);
            n_items = $urandom_range(30, 70);
            if (ph == HOLD_PHASE) begin
                // long receiver stall so the pipeline fills and s_ready drops
                idle_en  = 1'b0;
                hold_req = 1'b1;
                n_items  = 120;
            end
            repeat (n_items) begin
                case ($urandom_range(0, 3))
                    0, 1:    smp = 16'($urandom);
                    2:       smp = 16'($urandom_range(0, 2047) - 1024);
                    default: smp = corner_smp[$urandom_range(0, 4)];
                endcase
                sample_q = {sample_q, smp};
            end
        end

        drain();
        if (err_count == 0 && shaped_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (shaped_q.size() != 0)
                $error("sample_out: %0d predicted words never arrived", shaped_q.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
